### hw/rtl/sof_pkg.sv
// Shared types, constants and register map of the slot occupancy debounce block.
package sof_pkg;

   localparam int unsigned NumSlotsDefault   = 4;
   localparam int unsigned QueueDepthDefault = 2;
   localparam int unsigned InLanes           = 4;
   localparam int unsigned TimeW             = 48;
   localparam int unsigned CsrAddrW          = 5;
   localparam int unsigned CsrDataW          = 32;

   localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
   localparam logic [1:0] CODE_FREE     = 2'd1;
   localparam logic [1:0] CODE_OCCUPIED = 2'd2;

   localparam logic [7:0] ConfFull = 8'hFF;
   localparam logic [7:0] CountMax = 8'hFF;

   localparam logic [2:0] REG_SIGN_MIN_CONF     = 3'd0;
   localparam logic [2:0] REG_SIGN_CONFIRM      = 3'd1;
   localparam logic [2:0] REG_SIGN_HOLD_TIME    = 3'd2;
   localparam logic [2:0] REG_OCCUPIED_CONFIRM  = 3'd3;
   localparam logic [2:0] REG_FREE_CONFIRM      = 3'd4;
   localparam logic [2:0] REG_SLOT_TIMEOUT      = 3'd5;

   typedef logic [TimeW-1:0] time_type;

   typedef struct packed {
      logic [7:0]  sign_min_conf;
      logic [7:0]  sign_confirm_count;
      logic [15:0] sign_hold_time;
      logic [7:0]  occupied_confirm_count;
      logic [7:0]  free_confirm_count;
      logic [15:0] slot_timeout;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      sign_min_conf:          8'd128,
      sign_confirm_count:     8'd3,
      sign_hold_time:         16'd5000,
      occupied_confirm_count: 8'd3,
      free_confirm_count:     8'd3,
      slot_timeout:           16'd2000
   };

   typedef struct packed {
      time_type                     now_time;
      logic                         sign_hit;
      logic [InLanes-1:0]           visible_mask;
      logic [InLanes-1:0]           occupied_mask;
      logic [InLanes-1:0][7:0]      occ_conf;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hw/rtl/sof_front.sv
// Front end: accepts frames, drops repeated frame ids and classifies the sign hit.
module sof_front import sof_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [31:0]   req_frame_number,
   input  logic [47:0]   req_now_time,
   input  logic [7:0]    req_sign_conf,
   input  logic [3:0]    req_visible_mask,
   input  logic [3:0]    req_occupied_mask,
   input  logic [7:0]    req_occ_conf_zero,
   input  logic [7:0]    req_occ_conf_one,
   input  logic [7:0]    req_occ_conf_two,
   input  logic [7:0]    req_occ_conf_three,
   input  cfg_type       cfg,
   input  q_status_type  q_status,
   output logic          q_push,
   output item_type      q_item
);

   logic [31:0] prev_frame_ff, prev_frame_in;
   logic        frame_seen_ff, frame_seen_in;
   logic        accept;
   logic        repeated;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign repeated  = frame_seen_ff && (req_frame_number == prev_frame_ff);
   assign q_push    = accept && !repeated;

   always_comb begin
      q_item.now_time      = req_now_time;
      q_item.sign_hit      = (req_sign_conf >= cfg.sign_min_conf);
      q_item.visible_mask  = req_visible_mask;
      q_item.occupied_mask = req_occupied_mask;
      q_item.occ_conf      = {req_occ_conf_three, req_occ_conf_two,
                              req_occ_conf_one, req_occ_conf_zero};
   end

   always_comb begin
      prev_frame_in = prev_frame_ff;
      frame_seen_in = frame_seen_ff;
      if (accept) begin
         prev_frame_in = req_frame_number;
         frame_seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_frame_ff <= '0;
         frame_seen_ff <= 1'b0;
      end else begin
         prev_frame_ff <= prev_frame_in;
         frame_seen_ff <= frame_seen_in;
      end
   end

endmodule

### hw/rtl/sof_queue.sv
// Short queue of classified frames between the front end and the back end.
module sof_queue import sof_pkg::*; #(
   parameter int unsigned DEPTH = QueueDepthDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  item_type      push_item,
   input  logic          pop,
   output item_type      pop_item,
   output q_status_type  status
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CntW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("queue read while empty");

endmodule

### hw/rtl/sof_back.sv
// Back end: sign hold, per-slot debounce counters, freshness and the report register.
module sof_back import sof_pkg::*; #(
   parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  q_status_type  q_status,
   input  item_type      q_item,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_slot_codes,
   output logic [7:0]    rsp_out_conf_zero,
   output logic [7:0]    rsp_out_conf_one,
   output logic [7:0]    rsp_out_conf_two,
   output logic [7:0]    rsp_out_conf_three,
   output logic          rsp_sign_on,
   output logic [31:0]   rsp_report_seq
);

   logic [7:0]   sign_cnt_ff, sign_cnt_in, sign_cnt_sat;
   time_type     sign_until_ff, sign_until_in;
   logic [TimeW:0] hold_sum;
   time_type     hold_end;
   logic         confirm;
   logic         active;
   logic [31:0]  seq_ff, seq_in;

   logic [7:0]   occ_cnt_ff [NUM_SLOTS];
   logic [7:0]   occ_cnt_in [NUM_SLOTS];
   logic [7:0]   free_cnt_ff [NUM_SLOTS];
   logic [7:0]   free_cnt_in [NUM_SLOTS];
   time_type     last_ev_ff [NUM_SLOTS];
   time_type     last_ev_in [NUM_SLOTS];
   logic [1:0]   code_ff [NUM_SLOTS];
   logic [1:0]   code_in [NUM_SLOTS];
   logic [7:0]   conf_ff [NUM_SLOTS];
   logic [7:0]   conf_in [NUM_SLOTS];

   logic [InLanes-1:0][1:0] out_code;
   logic [InLanes-1:0][7:0] out_conf;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_codes_ff;
   logic [InLanes-1:0][7:0] rsp_conf_ff;
   logic                    rsp_sign_ff;
   logic [31:0]             rsp_seq_ff;

   assign q_pop        = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);

   always_comb begin
      sign_cnt_sat = (sign_cnt_ff == CountMax) ? CountMax : sign_cnt_ff + 1'b1;
      hold_sum     = {1'b0, q_item.now_time} + (TimeW + 1)'(cfg.sign_hold_time);
      hold_end     = hold_sum[TimeW] ? '1 : hold_sum[TimeW-1:0];
      confirm      = q_item.sign_hit && (sign_cnt_sat >= cfg.sign_confirm_count);
      sign_cnt_in  = q_item.sign_hit ? sign_cnt_sat : '0;
      sign_until_in = confirm ? hold_end : sign_until_ff;
      if (confirm) begin
         active = (hold_end != '0);
      end else begin
         active = (sign_until_ff != '0) && (q_item.now_time <= sign_until_ff);
      end
      seq_in = seq_ff + 1'b1;
   end

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
      logic           vis;
      logic           occ;
      logic [7:0]     conf_new;
      logic           seen;
      logic [7:0]     occ_sat;
      logic [7:0]     free_sat;
      logic [TimeW:0] age;
      logic           fresh_old;
      logic           stale;

      if (i < InLanes) begin : g_lane
         assign vis      = q_item.visible_mask[i];
         assign occ      = q_item.occupied_mask[i];
         assign conf_new = q_item.occ_conf[i];
      end else begin : g_none
         assign vis      = 1'b0;
         assign occ      = 1'b0;
         assign conf_new = '0;
      end

      always_comb begin
         seen      = active && vis;
         occ_sat   = (occ_cnt_ff[i] == CountMax) ? CountMax : occ_cnt_ff[i] + 1'b1;
         free_sat  = (free_cnt_ff[i] == CountMax) ? CountMax : free_cnt_ff[i] + 1'b1;
         age       = {1'b0, q_item.now_time} - {1'b0, last_ev_ff[i]};
         fresh_old = !age[TimeW] && (age[TimeW-1:16] == '0) &&
                     (age[15:0] <= cfg.slot_timeout);

         occ_cnt_in[i]  = occ_cnt_ff[i];
         free_cnt_in[i] = free_cnt_ff[i];
         last_ev_in[i]  = last_ev_ff[i];
         code_in[i]     = code_ff[i];
         conf_in[i]     = conf_ff[i];

         if (seen && occ) begin
            occ_cnt_in[i]  = occ_sat;
            free_cnt_in[i] = '0;
            last_ev_in[i]  = q_item.now_time;
            if (occ_sat >= cfg.occupied_confirm_count) begin
               code_in[i] = CODE_OCCUPIED;
               conf_in[i] = conf_new;
            end else if (code_ff[i] == CODE_FREE) begin
               code_in[i] = CODE_UNKNOWN;
               conf_in[i] = '0;
            end
         end else if (seen) begin
            free_cnt_in[i] = free_sat;
            occ_cnt_in[i]  = '0;
            last_ev_in[i]  = q_item.now_time;
            if (free_sat >= cfg.free_confirm_count) begin
               code_in[i] = CODE_FREE;
               conf_in[i] = ConfFull;
            end
         end

         if (seen) begin
            stale = !active || (q_item.now_time == '0);
         end else begin
            stale = !active || (last_ev_ff[i] == '0) || !fresh_old;
         end
         if (stale) begin
            code_in[i] = CODE_UNKNOWN;
            conf_in[i] = '0;
            if (!active) begin
               occ_cnt_in[i]  = '0;
               free_cnt_in[i] = '0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            occ_cnt_ff[i]  <= '0;
            free_cnt_ff[i] <= '0;
            last_ev_ff[i]  <= '0;
            code_ff[i]     <= CODE_UNKNOWN;
            conf_ff[i]     <= '0;
         end else if (q_pop) begin
            occ_cnt_ff[i]  <= occ_cnt_in[i];
            free_cnt_ff[i] <= free_cnt_in[i];
            last_ev_ff[i]  <= last_ev_in[i];
            code_ff[i]     <= code_in[i];
            conf_ff[i]     <= conf_in[i];
         end
      end
   end

   for (genvar j = 0; j < InLanes; j++) begin : g_out
      if (j < NUM_SLOTS) begin : g_used
         assign out_code[j] = code_in[j];
         assign out_conf[j] = conf_in[j];
      end else begin : g_unused
         assign out_code[j] = CODE_UNKNOWN;
         assign out_conf[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_cnt_ff   <= '0;
         sign_until_ff <= '0;
         seq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            sign_cnt_ff   <= sign_cnt_in;
            sign_until_ff <= sign_until_in;
            seq_ff        <= seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_codes_ff <= out_code;
         rsp_conf_ff  <= out_conf;
         rsp_sign_ff  <= active;
         rsp_seq_ff   <= seq_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_codes     = rsp_codes_ff;
   assign rsp_out_conf_zero  = rsp_conf_ff[0];
   assign rsp_out_conf_one   = rsp_conf_ff[1];
   assign rsp_out_conf_two   = rsp_conf_ff[2];
   assign rsp_out_conf_three = rsp_conf_ff[3];
   assign rsp_sign_on        = rsp_sign_ff;
   assign rsp_report_seq     = rsp_seq_ff;

   a_no_pop_while_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !q_pop)
      else $error("report overwritten while stalled");

   a_sign_off_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_sign_ff |-> rsp_codes_ff == '0)
      else $error("slot state reported with sign inactive");

   for (genvar k = 0; k < InLanes; k++) begin : g_chk
      a_free_full_conf: assert property (@(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_codes_ff[2*k+1 -: 2] == CODE_FREE |->
         rsp_conf_ff[k] == ConfFull)
         else $error("free slot without full confidence");
   end

endmodule

### hw/rtl/slot_occupancy_debounce.sv
// Top level of the slot occupancy debounce block: register file, front end, queue, back end.
//
//  channel  direction  handshake                     payload
//  req      in         req_valid / req_stall         frame, time, sign conf, masks, slot confs
//  rsp      out        rsp_valid / rsp_stall         slot codes, slot confs, sign flag, sequence
//  csr      in/out     psel penable pwrite pready    paddr, pwdata, prdata
//
// One frame a cycle while not stalled; frames pass the queue into the report register.
// A repeated frame id is taken and dropped without a report.
// The back end settles sign hold and all slot updates of one frame together, as it pops it.
// Reset is synchronous; registers return to their defaults and all slots to unknown.
// The queue holds QUEUE_DEPTH frames, two by default; a stalled report backs up the front end once it is full.
module slot_occupancy_debounce import sof_pkg::*; #(
   parameter int unsigned NUM_SLOTS   = NumSlotsDefault,
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_frame_number,
   input  logic [47:0]          req_now_time,
   input  logic [7:0]           req_sign_conf,
   input  logic [3:0]           req_visible_mask,
   input  logic [3:0]           req_occupied_mask,
   input  logic [7:0]           req_occ_conf_zero,
   input  logic [7:0]           req_occ_conf_one,
   input  logic [7:0]           req_occ_conf_two,
   input  logic [7:0]           req_occ_conf_three,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_slot_codes,
   output logic [7:0]           rsp_out_conf_zero,
   output logic [7:0]           rsp_out_conf_one,
   output logic [7:0]           rsp_out_conf_two,
   output logic [7:0]           rsp_out_conf_three,
   output logic                 rsp_sign_on,
   output logic [31:0]          rsp_report_seq,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CsrAddrW-1:0]  paddr,
   input  logic [CsrDataW-1:0]  pwdata,
   output logic [CsrDataW-1:0]  prdata,
   output logic                 pready
);

   cfg_type       cfg_ff, cfg_in;
   logic [2:0]    reg_index;
   logic          csr_write;
   q_status_type  q_status;
   logic          q_push;
   logic          q_pop;
   item_type      push_item;
   item_type      pop_item;

   assign pready    = 1'b1;
   assign reg_index = paddr[CsrAddrW-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_SIGN_MIN_CONF:    cfg_in.sign_min_conf          = pwdata[7:0];
            REG_SIGN_CONFIRM:     cfg_in.sign_confirm_count     = pwdata[7:0];
            REG_SIGN_HOLD_TIME:   cfg_in.sign_hold_time         = pwdata[15:0];
            REG_OCCUPIED_CONFIRM: cfg_in.occupied_confirm_count = pwdata[7:0];
            REG_FREE_CONFIRM:     cfg_in.free_confirm_count     = pwdata[7:0];
            REG_SLOT_TIMEOUT:     cfg_in.slot_timeout           = pwdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SIGN_MIN_CONF:    prdata = CsrDataW'(cfg_ff.sign_min_conf);
         REG_SIGN_CONFIRM:     prdata = CsrDataW'(cfg_ff.sign_confirm_count);
         REG_SIGN_HOLD_TIME:   prdata = CsrDataW'(cfg_ff.sign_hold_time);
         REG_OCCUPIED_CONFIRM: prdata = CsrDataW'(cfg_ff.occupied_confirm_count);
         REG_FREE_CONFIRM:     prdata = CsrDataW'(cfg_ff.free_confirm_count);
         REG_SLOT_TIMEOUT:     prdata = CsrDataW'(cfg_ff.slot_timeout);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sof_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_number   (req_frame_number),
      .req_now_time       (req_now_time),
      .req_sign_conf      (req_sign_conf),
      .req_visible_mask   (req_visible_mask),
      .req_occupied_mask  (req_occupied_mask),
      .req_occ_conf_zero  (req_occ_conf_zero),
      .req_occ_conf_one   (req_occ_conf_one),
      .req_occ_conf_two   (req_occ_conf_two),
      .req_occ_conf_three (req_occ_conf_three),
      .cfg                (cfg_ff),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_item             (push_item)
   );

   sof_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   sof_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_status           (q_status),
      .q_item             (pop_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slot_codes     (rsp_slot_codes),
      .rsp_out_conf_zero  (rsp_out_conf_zero),
      .rsp_out_conf_one   (rsp_out_conf_one),
      .rsp_out_conf_two   (rsp_out_conf_two),
      .rsp_out_conf_three (rsp_out_conf_three),
      .rsp_sign_on        (rsp_sign_on),
      .rsp_report_seq     (rsp_report_seq)
   );

endmodule
